[src/spw_pkg.sv]
// ----------------------------------------------------------------------------
// spw_pkg
// Shared types and constants for the staged progress watchdog: item layouts,
// action codes, table size and the timeout register reset value.
// ----------------------------------------------------------------------------
package spw_pkg;

  // Number of stages tracked in the duration table
  localparam int NUM_STAGES = 16;

  // Field widths
  localparam int ACTION_W  = 2;
  localparam int STAGE_W   = 4;
  localparam int TIMEOUT_W = 25;
  localparam int HB_W      = 32;

  // Timeout register value after reset
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(630);

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [STAGE_W-1:0]  stage_index;
  } in_item_t;

  typedef struct packed {
    logic               fired;
    logic [STAGE_W-1:0] last_stage;
    logic               armed;
    logic               duration_valid;
    logic [HB_W-1:0]    duration_ticks;
  } out_item_t;

endpackage

[src/spw_core.sv]
// ----------------------------------------------------------------------------
// spw_core
// Watchdog state and stage duration table. On each step strobe the held item
// updates the state and the result reflecting the updated state is produced.
// ----------------------------------------------------------------------------
module spw_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [spw_pkg::TIMEOUT_W-1:0]  timeout,
  input  logic                           step,
  input  spw_pkg::in_item_t              item,
  output spw_pkg::out_item_t             result
);

  // Control state
  logic [spw_pkg::HB_W-1:0]    hb_r, hb_nxt;
  logic [spw_pkg::STAGE_W-1:0] cur_r, cur_nxt;
  logic                        started_r, started_nxt;
  logic                        fired_r, fired_nxt;
  logic [spw_pkg::NUM_STAGES-1:0] seen_r, seen_nxt;

  // Finished stage durations; an entry is written once, when its stage is left
  logic [spw_pkg::HB_W-1:0] dur_r [spw_pkg::NUM_STAGES];
  logic                     dur_we;

  logic                        in_range;
  logic                        adv_ok;
  logic                        tick_ok;
  logic                        q_valid;
  logic [spw_pkg::HB_W-1:0]    q_ticks;

  assign in_range = (32'(item.stage_index) < spw_pkg::NUM_STAGES);

  // Advance takes effect only forward, before firing
  assign adv_ok = !fired_r && in_range && (!started_r || (item.stage_index > cur_r));
  assign tick_ok = started_r && !fired_r;

  // Next state
  always_comb begin
    hb_nxt      = hb_r;
    cur_nxt     = cur_r;
    started_nxt = started_r;
    fired_nxt   = fired_r;
    seen_nxt    = seen_r;
    dur_we      = 1'b0;
    case (item.action)
      spw_pkg::ACT_TICK: begin
        if (tick_ok) begin
          if (hb_r != '1) begin
            hb_nxt = hb_r + spw_pkg::HB_W'(1);
          end
          if (hb_r >= spw_pkg::HB_W'(timeout)) begin
            fired_nxt = 1'b1;
          end
        end
      end
      spw_pkg::ACT_ADVANCE: begin
        if (adv_ok) begin
          dur_we                     = started_r;
          seen_nxt[item.stage_index] = 1'b1;
          hb_nxt                     = '0;
          cur_nxt                    = item.stage_index;
          started_nxt                = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Query: an ongoing stage reads zero, a finished one its recorded count
  always_comb begin
    q_valid = 1'b0;
    q_ticks = '0;
    if (item.action == spw_pkg::ACT_QUERY && in_range && seen_r[item.stage_index]) begin
      q_valid = 1'b1;
      if (!(started_r && item.stage_index == cur_r)) begin
        q_ticks = dur_r[item.stage_index];
      end
    end
  end

  // Result carries the state after this item
  always_comb begin
    result.fired          = fired_nxt;
    result.last_stage     = cur_nxt;
    result.armed          = started_nxt;
    result.duration_valid = q_valid;
    result.duration_ticks = q_ticks;
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r      <= '0;
      cur_r     <= '0;
      started_r <= 1'b0;
      fired_r   <= 1'b0;
      seen_r    <= '0;
    end else if (step) begin
      hb_r      <= hb_nxt;
      cur_r     <= cur_nxt;
      started_r <= started_nxt;
      fired_r   <= fired_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // Record the duration of the stage being left
  always_ff @(posedge clk) begin
    if (step && dur_we) begin
      dur_r[cur_r] <= hb_r;
    end
  end

endmodule

[src/staged_progress_watchdog.sv]
// ----------------------------------------------------------------------------
// staged_progress_watchdog
// Each accepted item is held in the input register, its result in the result
// register. Throughput: one item per cycle while out_ready does not stall the
// result register; set by the single-pass state update between both registers.
// Reset (rst_n low, synchronous): clears control state, not the stage table,
// sets the timeout register to 630; the block accepts items on the next cycle.
// ----------------------------------------------------------------------------
module staged_progress_watchdog (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  spw_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output spw_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [spw_pkg::TIMEOUT_W-1:0]  cfg_wdata
);

  logic [spw_pkg::TIMEOUT_W-1:0] timeout_r;
  logic                          s_vld_r;
  spw_pkg::in_item_t             s_item_r;
  logic                          o_vld_r;
  spw_pkg::out_item_t            o_item_r;
  spw_pkg::out_item_t            result;
  logic                          step;

  // Process the held item when the result register can take it
  assign step     = s_vld_r && (!o_vld_r || out_ready);
  assign in_ready = !s_vld_r || step;

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= spw_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_ready) begin
      s_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_item_r <= in_data;
    end
  end

  spw_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .timeout (timeout_r),
    .step    (step),
    .item    (s_item_r),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (step) begin
      o_vld_r <= 1'b1;
    end else if (out_ready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_item_r <= result;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_item_r;

endmodule

[tb/staged_progress_watchdog_tb.sv]
// ----------------------------------------------------------------------------
// staged_progress_watchdog_tb
// Self-checking bench for the staged progress watchdog. Items go in over a
// valid/ready channel. A predictor in the bench keeps its own copy of the
// heartbeat, the stage table and the timeout, and it queues one expected
// status for every accepted beat. Each result beat is compared with the oldest
// entry. Directed tests cover arming, stage ordering, the zero timeout and the
// behavior after firing. Random traffic runs under three idling patterns and
// several timeout settings.
// ----------------------------------------------------------------------------
module staged_progress_watchdog_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused action code: the block only reports status for it
  localparam logic [spw_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_MAX   = 10;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  spw_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  spw_pkg::out_item_t            out_data;
  logic                          cfg_we    = 1'b0;
  logic [spw_pkg::TIMEOUT_W-1:0] cfg_wdata = '0;

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  // Predicted watchdog state
  logic [spw_pkg::HB_W-1:0]      hb_count = '0;
  logic [spw_pkg::STAGE_W-1:0]   stage_now = '0;
  logic                          is_armed = 1'b0;
  logic                          has_fired = 1'b0;
  logic [spw_pkg::HB_W-1:0]      stage_ticks [spw_pkg::NUM_STAGES];
  logic                          stage_started [spw_pkg::NUM_STAGES] = '{default: 1'b0};
  logic [spw_pkg::TIMEOUT_W-1:0] timeout_val = spw_pkg::TIMEOUT_RESET;

  // Status expected for each accepted beat, oldest first
  spw_pkg::out_item_t pending_status [$];

  staged_progress_watchdog uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Apply one item to the predicted state and return the status it yields
  function automatic spw_pkg::out_item_t watchdog_step(spw_pkg::in_item_t it);
    spw_pkg::out_item_t       status;
    logic [spw_pkg::HB_W-1:0] prior;
    status = '0;
    case (it.action)
      spw_pkg::ACT_TICK: begin
        if (is_armed && !has_fired) begin
          prior = hb_count;
          if (hb_count != '1) hb_count = hb_count + spw_pkg::HB_W'(1);
          if (prior >= spw_pkg::HB_W'(timeout_val)) has_fired = 1'b1;
        end
      end
      spw_pkg::ACT_ADVANCE: begin
        // Only a higher stage counts, and nothing moves once fired
        if (!has_fired && int'(it.stage_index) < spw_pkg::NUM_STAGES &&
            (!is_armed || it.stage_index > stage_now)) begin
          if (is_armed) stage_ticks[stage_now] = hb_count;
          stage_ticks[it.stage_index]   = '0;
          stage_started[it.stage_index] = 1'b1;
          hb_count  = '0;
          stage_now = it.stage_index;
          is_armed  = 1'b1;
        end
      end
      spw_pkg::ACT_QUERY: begin
        if (int'(it.stage_index) < spw_pkg::NUM_STAGES &&
            stage_started[it.stage_index]) begin
          status.duration_valid = 1'b1;
          status.duration_ticks = stage_ticks[it.stage_index];
        end
      end
      default: ;
    endcase
    status.fired      = has_fired;
    status.last_stage = stage_now;
    status.armed      = is_armed;
    return status;
  endfunction

  function automatic void check_field(string field, logic [spw_pkg::HB_W-1:0] want,
                                      logic [spw_pkg::HB_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  // Compare every result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    spw_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result beat: %h", out_data);
      end else begin
        want = pending_status.pop_front();
        check_field("fired", spw_pkg::HB_W'(want.fired),
                    spw_pkg::HB_W'(out_data.fired));
        check_field("last_stage", spw_pkg::HB_W'(want.last_stage),
                    spw_pkg::HB_W'(out_data.last_stage));
        check_field("armed", spw_pkg::HB_W'(want.armed),
                    spw_pkg::HB_W'(out_data.armed));
        check_field("duration_valid", spw_pkg::HB_W'(want.duration_valid),
                    spw_pkg::HB_W'(out_data.duration_valid));
        check_field("duration_ticks", want.duration_ticks, out_data.duration_ticks);
      end
    end
  end

  // Send one beat, idling first at random; valid stays up for a follow-on beat
  task automatic send_item(input logic [spw_pkg::ACTION_W-1:0] act,
                           input logic [spw_pkg::STAGE_W-1:0] idx);
    spw_pkg::in_item_t it;
    it.action      = act;
    it.stage_index = idx;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_status.push_back(watchdog_step(it));
  endtask

  // Write the timeout once every outstanding result has come back
  task automatic write_timeout(input logic [spw_pkg::TIMEOUT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    timeout_val  = value;
  endtask

  // Ticks, an unused action and queries before any stage is reached
  task automatic test_before_arming;
    send_item(spw_pkg::ACT_TICK, 4'd0);
    send_item(ACT_RESERVED, 4'd15);
    send_item(spw_pkg::ACT_QUERY, 4'd5);
    send_item(spw_pkg::ACT_QUERY, 4'd0);
  endtask

  // Arm at stage zero, record durations, drop stages that are not higher
  task automatic test_stage_order;
    send_item(spw_pkg::ACT_ADVANCE, 4'd0);
    repeat (3) send_item(spw_pkg::ACT_TICK, 4'd9);
    send_item(spw_pkg::ACT_QUERY, 4'd0);
    send_item(spw_pkg::ACT_ADVANCE, 4'd2);
    send_item(spw_pkg::ACT_QUERY, 4'd0);
    send_item(spw_pkg::ACT_ADVANCE, 4'd1);
    send_item(spw_pkg::ACT_ADVANCE, 4'd2);
    send_item(spw_pkg::ACT_QUERY, 4'd2);
    send_item(spw_pkg::ACT_QUERY, 4'd1);
    send_item(spw_pkg::ACT_TICK, 4'd15);
    send_item(spw_pkg::ACT_QUERY, 4'd15);
  endtask

  // Mostly ticks and queries with rare in-order advances, plus stale advances
  task automatic run_random_traffic(input int count, input int src_pct,
                                    input int dst_pct);
    int                          pick;
    logic [spw_pkg::STAGE_W-1:0] target;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        send_item(spw_pkg::ACT_TICK, spw_pkg::STAGE_W'($urandom));
      end else if (pick < 87) begin
        send_item(spw_pkg::ACT_QUERY, spw_pkg::STAGE_W'($urandom));
      end else if (pick < 92) begin
        send_item(spw_pkg::ACT_ADVANCE,
                  spw_pkg::STAGE_W'($urandom_range(0, stage_now)));
      end else if (pick < 93) begin
        if (int'(stage_now) >= spw_pkg::NUM_STAGES - 2)
          target = spw_pkg::STAGE_W'($urandom);
        else
          target = stage_now + spw_pkg::STAGE_W'($urandom_range(1, 2));
        send_item(spw_pkg::ACT_ADVANCE, target);
      end else begin
        send_item(ACT_RESERVED, spw_pkg::STAGE_W'($urandom));
      end
    end
  endtask

  // With a zero timeout the next tick fires right after progress
  task automatic test_zero_timeout;
    write_timeout('0);
    if (int'(stage_now) < spw_pkg::NUM_STAGES - 1)
      send_item(spw_pkg::ACT_ADVANCE, stage_now + spw_pkg::STAGE_W'(1));
    send_item(spw_pkg::ACT_TICK, 4'd3);
    send_item(spw_pkg::ACT_QUERY, stage_now);
  endtask

  // Once fired, ticks and advances are dead; every stage still answers
  task automatic test_after_fire;
    send_item(spw_pkg::ACT_TICK, 4'd0);
    send_item(spw_pkg::ACT_ADVANCE, 4'd15);
    send_item(spw_pkg::ACT_ADVANCE, 4'd0);
    send_item(ACT_RESERVED, 4'd7);
    for (int s = 0; s < spw_pkg::NUM_STAGES; s++)
      send_item(spw_pkg::ACT_QUERY, spw_pkg::STAGE_W'(s));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 22;
    dst_idle_pct = 56;
    test_before_arming;
    test_stage_order;

    write_timeout('1);
    run_random_traffic(640, 22, 56);
    write_timeout(spw_pkg::TIMEOUT_W'($urandom_range(200, 2000)));
    run_random_traffic(640, 56, 22);
    write_timeout(spw_pkg::TIMEOUT_W'($urandom_range(1, (1 << spw_pkg::TIMEOUT_W) - 1)));
    run_random_traffic(640, 0, 0);

    test_zero_timeout;
    test_after_fire;

    // Drain, then allow time for any stray beat
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
